@@ src/lsls_pkg.sv @@
package lsls_pkg;

  // Field and register widths.
  localparam int unsigned CmdWidth      = 3;
  localparam int unsigned StateWidth    = 3;
  localparam int unsigned DebounceWidth = 10;
  localparam int unsigned StallWidth    = 16;
  localparam int unsigned DutyWidth     = 8;
  localparam int unsigned MaskWidth     = 5;
  localparam int unsigned IndexWidth    = 3;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 16;

  // Number of magnets that a set magnet command may address.
  localparam int unsigned MagnetCount = 5;

  // Mask value for set all with energize.
  localparam logic [MaskWidth-1:0] AllMagnets = 5'h1F;

  // Saturation values of the counters.
  localparam logic [DebounceWidth-1:0] SinceMax   = '1;
  localparam logic [StallWidth-1:0]    ElapsedMax = '1;

  // Reset values of the configuration registers.
  localparam logic [DebounceWidth-1:0] DebounceReset = 10'd20;
  localparam logic [StallWidth-1:0]    StallReset    = 16'd5000;
  localparam logic [DutyWidth-1:0]     DutyReset     = 8'd200;

  // Input commands.
  typedef enum logic [CmdWidth-1:0] {
    CMD_TICK        = 3'd0,
    CMD_RAISE       = 3'd1,
    CMD_LOWER       = 3'd2,
    CMD_STOP        = 3'd3,
    CMD_CLEAR_FAULT = 3'd4,
    CMD_SET_MAGNET  = 3'd5,
    CMD_SET_ALL     = 3'd6,
    CMD_UNUSED      = 3'd7
  } cmd_t;

  // Lift states as reported on lift_state.
  typedef enum logic [StateWidth-1:0] {
    MODE_IDLE     = 3'd0,
    MODE_RAISING  = 3'd1,
    MODE_RAISED   = 3'd2,
    MODE_LOWERING = 3'd3,
    MODE_LOWERED  = 3'd4,
    MODE_FAULT    = 3'd5
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DEBOUNCE_TICKS     = 3'd0,
    REG_STALL_LIMIT_TICKS  = 3'd1,
    REG_DRIVE_DUTY         = 3'd2,
    REG_SWITCH_ACTIVE_HIGH = 3'd3,
    REG_SHARED_RELAY       = 3'd4
  } cfg_reg_t;

  // Debouncer state of one switch.
  typedef struct packed {
    logic [DebounceWidth-1:0] since;
    logic                     stable;
  } switch_state_t;

  // One debounce step on a tick.
  function automatic switch_state_t debounce_step(
    input logic                     level,
    input logic                     active_high,
    input logic [DebounceWidth-1:0] ticks,
    input switch_state_t            cur
  );
    logic                     pressed;
    logic [DebounceWidth-1:0] since_inc;
    switch_state_t            res;
    pressed   = active_high ? level : ~level;
    since_inc = (cur.since < SinceMax) ? cur.since + 1'b1 : cur.since;
    res       = cur;
    if (pressed != cur.stable) begin
      if (since_inc >= ticks) begin
        res.stable = pressed;
        res.since  = '0;
      end else begin
        res.since = since_inc;
      end
    end else begin
      res.since = '0;
    end
    return res;
  endfunction

endpackage

@@ src/limit_switch_lift_sequencer.sv @@
// Lift motor sequencer with debounced limit switches and a magnet bank.
// Input channel (in_valid/in_ready) carries one item per transfer: a
// one-millisecond tick with raw switch levels, or a command (raise, lower,
// stop, clear fault, set magnet, set all). Every accepted item yields
// exactly one result transfer on the output channel (out_valid/out_ready)
// showing the state after that item.
// The result is in the output register on the cycle after the input
// transfer. Throughput is one item per cycle while out_ready stays high;
// the state update for an item is a few compares and counter increments
// done in the cycle of acceptance.
// While the receiver stalls, the held result stays put and in_ready drops;
// an item is taken in the same cycle that the waiting result is taken.
// The configuration port writes one register per cycle with cfg_write,
// cfg_index and cfg_data; the user must write only while no result is
// pending; the block does not enforce this. Synchronous reset puts the
// lift in idle, motor stopped, direction up, both switches released,
// magnets off, counters cleared, and config registers at their defaults.
module limit_switch_lift_sequencer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lsls_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [lsls_pkg::CfgDataWidth-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lsls_pkg::CmdWidth-1:0]       cmd,
  input  logic                                top_level,
  input  logic                                bottom_level,
  input  logic [lsls_pkg::IndexWidth-1:0]     magnet_index,
  input  logic                                magnet_on,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [lsls_pkg::StateWidth-1:0]     lift_state,
  output logic [lsls_pkg::DutyWidth-1:0]      motor_duty,
  output logic                                motor_up,
  output logic                                top_pressed,
  output logic                                bottom_pressed,
  output logic [lsls_pkg::MaskWidth-1:0]      magnet_bits,
  output logic                                relay_on
);

  // Configuration registers.
  logic [lsls_pkg::DebounceWidth-1:0] debounce_ticks;
  logic [lsls_pkg::StallWidth-1:0]    stall_limit_ticks;
  logic [lsls_pkg::DutyWidth-1:0]     drive_duty;
  logic                               switch_active_high;
  logic                               shared_relay;

  // Sequencer state.
  lsls_pkg::mode_t                 mode, mode_next;
  logic [lsls_pkg::StallWidth-1:0] motion_elapsed, motion_elapsed_next;
  lsls_pkg::switch_state_t         top_sw, top_sw_next;
  lsls_pkg::switch_state_t         bottom_sw, bottom_sw_next;
  logic [lsls_pkg::MaskWidth-1:0]  magnet_mask, magnet_mask_next;
  logic                            drive_up, drive_up_next;
  logic                            driving, driving_next;

  logic                            in_xfer;
  logic [lsls_pkg::StallWidth-1:0] elapsed_inc;
  lsls_pkg::cmd_t                  cmd_code;

  assign cmd_code = lsls_pkg::cmd_t'(cmd);
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;
  assign elapsed_inc = (motion_elapsed < lsls_pkg::ElapsedMax) ?
                       motion_elapsed + 1'b1 : motion_elapsed;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= lsls_pkg::DebounceReset;
      stall_limit_ticks  <= lsls_pkg::StallReset;
      drive_duty         <= lsls_pkg::DutyReset;
      switch_active_high <= 1'b0;
      shared_relay       <= 1'b1;
    end else if (cfg_write) begin
      case (lsls_pkg::cfg_reg_t'(cfg_index))
        lsls_pkg::REG_DEBOUNCE_TICKS:
          debounce_ticks <= cfg_data[lsls_pkg::DebounceWidth-1:0];
        lsls_pkg::REG_STALL_LIMIT_TICKS:
          stall_limit_ticks <= cfg_data[lsls_pkg::StallWidth-1:0];
        lsls_pkg::REG_DRIVE_DUTY:
          drive_duty <= cfg_data[lsls_pkg::DutyWidth-1:0];
        lsls_pkg::REG_SWITCH_ACTIVE_HIGH:
          switch_active_high <= cfg_data[0];
        lsls_pkg::REG_SHARED_RELAY:
          shared_relay <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Next state for the item at the input.
  always_comb begin
    mode_next           = mode;
    motion_elapsed_next = motion_elapsed;
    top_sw_next         = top_sw;
    bottom_sw_next      = bottom_sw;
    magnet_mask_next    = magnet_mask;
    drive_up_next       = drive_up;
    driving_next        = driving;
    case (cmd_code)
      lsls_pkg::CMD_TICK: begin
        top_sw_next = lsls_pkg::debounce_step(top_level, switch_active_high,
                                              debounce_ticks, top_sw);
        bottom_sw_next = lsls_pkg::debounce_step(bottom_level, switch_active_high,
                                                 debounce_ticks, bottom_sw);
        if (mode == lsls_pkg::MODE_RAISING || mode == lsls_pkg::MODE_LOWERING) begin
          motion_elapsed_next = elapsed_inc;
          // The limit switch wins over the stall timeout.
          if ((mode == lsls_pkg::MODE_RAISING) ? top_sw_next.stable
                                               : bottom_sw_next.stable) begin
            driving_next = 1'b0;
            mode_next    = (mode == lsls_pkg::MODE_RAISING) ?
                           lsls_pkg::MODE_RAISED : lsls_pkg::MODE_LOWERED;
          end else if (elapsed_inc > stall_limit_ticks) begin
            driving_next = 1'b0;
            mode_next    = lsls_pkg::MODE_FAULT;
          end
        end else if (mode == lsls_pkg::MODE_LOWERED) begin
          mode_next = lsls_pkg::MODE_IDLE;
        end
      end
      lsls_pkg::CMD_RAISE: begin
        if (mode != lsls_pkg::MODE_RAISING && mode != lsls_pkg::MODE_RAISED &&
            mode != lsls_pkg::MODE_FAULT) begin
          if (top_sw.stable) begin
            mode_next = lsls_pkg::MODE_RAISED;
          end else begin
            drive_up_next       = 1'b1;
            driving_next        = 1'b1;
            motion_elapsed_next = '0;
            mode_next           = lsls_pkg::MODE_RAISING;
          end
        end
      end
      lsls_pkg::CMD_LOWER: begin
        if (mode != lsls_pkg::MODE_LOWERING && mode != lsls_pkg::MODE_LOWERED &&
            mode != lsls_pkg::MODE_FAULT) begin
          if (bottom_sw.stable) begin
            mode_next = lsls_pkg::MODE_IDLE;
          end else begin
            drive_up_next       = 1'b0;
            driving_next        = 1'b1;
            motion_elapsed_next = '0;
            mode_next           = lsls_pkg::MODE_LOWERING;
          end
        end
      end
      lsls_pkg::CMD_STOP: begin
        driving_next = 1'b0;
        if (mode != lsls_pkg::MODE_FAULT) begin
          mode_next = lsls_pkg::MODE_IDLE;
        end
      end
      lsls_pkg::CMD_CLEAR_FAULT: begin
        driving_next = 1'b0;
        mode_next    = lsls_pkg::MODE_IDLE;
      end
      lsls_pkg::CMD_SET_MAGNET: begin
        // Indexes past the magnet count or the mask width change nothing.
        for (int i = 0; i < lsls_pkg::MaskWidth; i++) begin
          if (i < lsls_pkg::MagnetCount &&
              magnet_index == lsls_pkg::IndexWidth'(i)) begin
            magnet_mask_next[i] = magnet_on;
          end
        end
      end
      lsls_pkg::CMD_SET_ALL: begin
        magnet_mask_next = magnet_on ? lsls_pkg::AllMagnets : '0;
      end
      default: begin
      end
    endcase
  end

  // State registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lsls_pkg::MODE_IDLE;
      motion_elapsed <= '0;
      top_sw         <= '0;
      bottom_sw      <= '0;
      magnet_mask    <= '0;
      drive_up       <= 1'b1;
      driving        <= 1'b0;
    end else if (in_xfer) begin
      mode           <= mode_next;
      motion_elapsed <= motion_elapsed_next;
      top_sw         <= top_sw_next;
      bottom_sw      <= bottom_sw_next;
      magnet_mask    <= magnet_mask_next;
      drive_up       <= drive_up_next;
      driving        <= driving_next;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Result register, loaded with the state after the item.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      lift_state     <= mode_next;
      motor_duty     <= driving_next ? drive_duty : '0;
      motor_up       <= drive_up_next;
      top_pressed    <= top_sw_next.stable;
      bottom_pressed <= bottom_sw_next.stable;
      magnet_bits    <= magnet_mask_next;
      relay_on       <= shared_relay && (magnet_mask_next != '0);
    end
  end

  // The motor is never driven in fault.
  a_fault_stopped: assert property (@(posedge clk) disable iff (rst)
    (mode == lsls_pkg::MODE_FAULT) |-> !driving)
    else $error("motor driven while in fault");

  // A stop transfer always stops the motor.
  a_stop_stops: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cmd_code == lsls_pkg::CMD_STOP) |=> !driving)
    else $error("motor still driven after stop");

  // A tick in lowered reports idle.
  a_lowered_tick: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && cmd_code == lsls_pkg::CMD_TICK && mode == lsls_pkg::MODE_LOWERED)
    |=> (lift_state == lsls_pkg::MODE_IDLE))
    else $error("lowered did not return to idle on tick");

  // Reported duty matches the drive state after each transfer.
  a_duty_follows: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (motor_duty == (driving ? drive_duty : '0)))
    else $error("motor duty does not follow drive state");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

package lift_check_pkg;
  import lsls_pkg::*;

  // One reported lift status, in port order.
  typedef struct packed {
    mode_t                  state;
    logic [DutyWidth-1:0]   duty;
    logic                   up;
    logic                   top;
    logic                   bottom;
    logic [MaskWidth-1:0]   mask;
    logic                   relay;
  } lift_status_t;

  // Tracks the lift sequencer and holds the statuses still owed by the block.
  class lift_scoreboard;
    logic [DebounceWidth-1:0] debounce_ticks;
    logic [StallWidth-1:0]    stall_limit;
    logic [DutyWidth-1:0]     drive_duty;
    logic                     active_high;
    logic                     shared_relay;

    mode_t                    lift_mode;
    logic [StallWidth-1:0]    move_ticks;
    switch_state_t            top_sw;
    switch_state_t            bottom_sw;
    logic [MaskWidth-1:0]     mask;
    logic                     dir_up;
    logic                     motor_on;

    lift_status_t             expected_status[$];
    int unsigned              errors;

    function new();
      errors = 0;
      apply_reset();
    endfunction

    // State and registers as they come out of reset.
    function void apply_reset();
      debounce_ticks = DebounceReset;
      stall_limit    = StallReset;
      drive_duty     = DutyReset;
      active_high    = 1'b0;
      shared_relay   = 1'b1;
      lift_mode      = MODE_IDLE;
      move_ticks     = '0;
      top_sw         = '0;
      bottom_sw      = '0;
      mask           = '0;
      dir_up         = 1'b1;
      motor_on       = 1'b0;
      expected_status.delete();
    endfunction

    function void load_reg(cfg_reg_t idx, logic [CfgDataWidth-1:0] value);
      case (idx)
        REG_DEBOUNCE_TICKS:     debounce_ticks = value[DebounceWidth-1:0];
        REG_STALL_LIMIT_TICKS:  stall_limit = value[StallWidth-1:0];
        REG_DRIVE_DUTY:         drive_duty = value[DutyWidth-1:0];
        REG_SWITCH_ACTIVE_HIGH: active_high = value[0];
        REG_SHARED_RELAY:       shared_relay = value[0];
        default: ;
      endcase
    endfunction

    // A changed reading is taken once its age reaches the debounce time.
    function switch_state_t filter_switch(logic level, switch_state_t cur);
      switch_state_t nxt;
      logic          pressed;
      pressed = active_high ? level : ~level;
      nxt = cur;
      if (nxt.since != SinceMax) begin
        nxt.since = nxt.since + 1'b1;
      end
      if (pressed == cur.stable) begin
        nxt.since = '0;
      end else if (nxt.since >= debounce_ticks) begin
        nxt.stable = pressed;
        nxt.since  = '0;
      end
      return nxt;
    endfunction

    // One tick of motion: the limit switch wins over the stall timeout.
    function void advance_motion(logic at_limit, mode_t done_mode);
      if (move_ticks != ElapsedMax) begin
        move_ticks = move_ticks + 1'b1;
      end
      if (at_limit) begin
        motor_on  = 1'b0;
        lift_mode = done_mode;
      end else if (move_ticks > stall_limit) begin
        motor_on  = 1'b0;
        lift_mode = MODE_FAULT;
      end
    endfunction

    function void start_motion(logic up, mode_t next_mode);
      dir_up     = up;
      motor_on   = 1'b1;
      move_ticks = '0;
      lift_mode  = next_mode;
    endfunction

    // Applies one accepted input transfer and queues the status it produces.
    function void note_item(cmd_t c, logic top_lvl, logic bot_lvl,
                            logic [IndexWidth-1:0] idx, logic on);
      lift_status_t want;
      case (c)
        CMD_TICK: begin
          top_sw    = filter_switch(top_lvl, top_sw);
          bottom_sw = filter_switch(bot_lvl, bottom_sw);
          if (lift_mode == MODE_RAISING) begin
            advance_motion(top_sw.stable, MODE_RAISED);
          end else if (lift_mode == MODE_LOWERING) begin
            advance_motion(bottom_sw.stable, MODE_LOWERED);
          end else if (lift_mode == MODE_LOWERED) begin
            lift_mode = MODE_IDLE;
          end
        end
        CMD_RAISE: begin
          if (lift_mode != MODE_RAISING && lift_mode != MODE_RAISED &&
              lift_mode != MODE_FAULT) begin
            if (top_sw.stable) lift_mode = MODE_RAISED;
            else start_motion(1'b1, MODE_RAISING);
          end
        end
        CMD_LOWER: begin
          if (lift_mode != MODE_LOWERING && lift_mode != MODE_LOWERED &&
              lift_mode != MODE_FAULT) begin
            if (bottom_sw.stable) lift_mode = MODE_IDLE;
            else start_motion(1'b0, MODE_LOWERING);
          end
        end
        CMD_STOP: begin
          motor_on = 1'b0;
          if (lift_mode != MODE_FAULT) lift_mode = MODE_IDLE;
        end
        CMD_CLEAR_FAULT: begin
          motor_on  = 1'b0;
          lift_mode = MODE_IDLE;
        end
        CMD_SET_MAGNET: begin
          if (idx < MagnetCount) mask[idx] = on;
        end
        CMD_SET_ALL: begin
          mask = on ? AllMagnets : '0;
        end
        default: ;
      endcase
      want.state  = lift_mode;
      want.duty   = motor_on ? drive_duty : '0;
      want.up     = dir_up;
      want.top    = top_sw.stable;
      want.bottom = bottom_sw.stable;
      want.mask   = mask;
      want.relay  = shared_relay && (mask != '0);
      expected_status.push_back(want);
    endfunction

    function int unsigned pending();
      return expected_status.size();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compares one output transfer with the oldest owed status.
    function void check_result(lift_status_t got);
      lift_status_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result, lift_state %0d", $time, got.state);
        errors++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("lift_state", 32'(want.state), 32'(got.state));
      compare_field("motor_duty", 32'(want.duty), 32'(got.duty));
      compare_field("motor_up", 32'(want.up), 32'(got.up));
      compare_field("top_pressed", 32'(want.top), 32'(got.top));
      compare_field("bottom_pressed", 32'(want.bottom), 32'(got.bottom));
      compare_field("magnet_bits", 32'(want.mask), 32'(got.mask));
      compare_field("relay_on", 32'(want.relay), 32'(got.relay));
    endfunction
  endclass

endpackage

module tb;
  import lsls_pkg::*;
  import lift_check_pkg::*;

  localparam int unsigned WatchdogLimit  = 5000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned PhaseCount     = 10;
  localparam int unsigned PhaseItems     = 120;
  localparam int unsigned LongMoveTicks  = 40;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [CmdWidth-1:0]      cmd;
  logic                     top_level;
  logic                     bottom_level;
  logic [IndexWidth-1:0]    magnet_index;
  logic                     magnet_on;
  logic                     out_valid;
  logic                     out_ready;
  logic [StateWidth-1:0]    lift_state;
  logic [DutyWidth-1:0]     motor_duty;
  logic                     motor_up;
  logic                     top_pressed;
  logic                     bottom_pressed;
  logic [MaskWidth-1:0]     magnet_bits;
  logic                     relay_on;

  lift_scoreboard board;
  logic           long_hold;
  int unsigned    idle_cycles;

  limit_switch_lift_sequencer uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .top_level      (top_level),
    .bottom_level   (bottom_level),
    .magnet_index   (magnet_index),
    .magnet_on      (magnet_on),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .lift_state     (lift_state),
    .motor_duty     (motor_duty),
    .motor_up       (motor_up),
    .top_pressed    (top_pressed),
    .bottom_pressed (bottom_pressed),
    .magnet_bits    (magnet_bits),
    .relay_on       (relay_on)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Gap length: short with 85 percent odds, else a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Observes every transfer and register write at the rising edge.
  always @(posedge clk) begin : monitor
    lift_status_t seen;
    if (rst) begin
      board.apply_reset();
    end else begin
      if (out_valid && out_ready) begin
        seen.state  = mode_t'(lift_state);
        seen.duty   = motor_duty;
        seen.up     = motor_up;
        seen.top    = top_pressed;
        seen.bottom = bottom_pressed;
        seen.mask   = magnet_bits;
        seen.relay  = relay_on;
        board.check_result(seen);
      end
      if (in_valid && in_ready) begin
        board.note_item(cmd_t'(cmd), top_level, bottom_level, magnet_index, magnet_on);
      end
      if (cfg_write) begin
        board.load_reg(cfg_reg_t'(cfg_index), cfg_data);
      end
    end
  end

  // Ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d results owed", $time, board.pending());
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: steady stretches, random stalls, and a long hold on request.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned span;
    bit          steady;
    out_ready  = 1'b0;
    stall_left = 0;
    span       = 0;
    steady     = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk);
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else begin
        if (span == 0) begin
          steady = ($urandom_range(0, 3) == 0);
          span   = $urandom_range(20, 200);
        end
        span--;
        if (stall_left != 0) begin
          out_ready <= 1'b0;
          stall_left--;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap() - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Offers one item and returns at the edge where the transfer happens.
  task automatic send_item(cmd_t c, logic t, logic b, logic [IndexWidth-1:0] idx,
                           logic on);
    @(negedge clk);
    in_valid     <= 1'b1;
    cmd          <= c;
    top_level    <= t;
    bottom_level <= b;
    magnet_index <= idx;
    magnet_on    <= on;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the input channel empty for the given number of cycles.
  task automatic pause_input(int unsigned cycles);
    if (cycles == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Writes one register once every owed status has come back.
  task automatic set_reg(cfg_reg_t idx, logic [CfgDataWidth-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic apply_settings(int unsigned deb, int unsigned stall, int unsigned duty,
                                bit high, bit shared);
    set_reg(REG_DEBOUNCE_TICKS, CfgDataWidth'(deb));
    set_reg(REG_STALL_LIMIT_TICKS, CfgDataWidth'(stall));
    set_reg(REG_DRIVE_DUTY, CfgDataWidth'(duty));
    set_reg(REG_SWITCH_ACTIVE_HIGH, CfgDataWidth'(high));
    set_reg(REG_SHARED_RELAY, CfgDataWidth'(shared));
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned roll;
    int unsigned deb;
    int unsigned stall;
    bit          back_to_back;
    cmd_t        c;
    logic        top_lvl;
    logic        bot_lvl;
    logic        t;
    logic        b;

    board        = new();
    long_hold    = 1'b0;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    cmd          = CMD_TICK;
    top_level    = 1'b1;
    bottom_level = 1'b1;
    magnet_index = '0;
    magnet_on    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: switches are active low.
    send_item(CMD_TICK, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_SET_MAGNET, 1'b0, 1'b0, 3'd0, 1'b1);
    send_item(CMD_SET_MAGNET, 1'b0, 1'b0, 3'd4, 1'b1);
    send_item(CMD_SET_MAGNET, 1'b0, 1'b0, 3'd5, 1'b1);
    send_item(CMD_SET_MAGNET, 1'b1, 1'b1, 3'd7, 1'b1);
    send_item(CMD_SET_MAGNET, 1'b0, 1'b0, 3'd4, 1'b0);
    send_item(CMD_SET_ALL, 1'b0, 1'b0, 3'd0, 1'b1);
    send_item(CMD_SET_ALL, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_UNUSED, 1'b1, 1'b1, 3'd7, 1'b1);
    send_item(CMD_RAISE, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_RAISE, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_STOP, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_LOWER, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_CLEAR_FAULT, 1'b0, 1'b0, 3'd0, 1'b0);

    // Instant debounce and a one-tick stall limit: fault, then both limits.
    set_reg(REG_DEBOUNCE_TICKS, CfgDataWidth'(0));
    set_reg(REG_STALL_LIMIT_TICKS, CfgDataWidth'(1));
    send_item(CMD_RAISE, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_RAISE, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_LOWER, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_STOP, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_CLEAR_FAULT, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b0, 1'b1, 3'd0, 1'b0);
    send_item(CMD_RAISE, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_LOWER, 1'b1, 1'b1, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b0, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b1, 1'b0, 3'd0, 1'b0);
    send_item(CMD_LOWER, 1'b1, 1'b0, 3'd0, 1'b0);

    // Random phases, each under fresh settings; the first two take the extremes.
    top_lvl = 1'b1;
    bot_lvl = 1'b1;
    for (phase = 0; phase < PhaseCount; phase++) begin
      if (phase == 0) begin
        apply_settings(0, 0, 0, 1'b0, 1'b0);
      end else if (phase == 1) begin
        apply_settings(1023, 65535, 255, 1'b1, 1'b1);
      end else begin
        case ($urandom_range(0, 3))
          0: deb = 0;
          1: deb = $urandom_range(1, 4);
          2: deb = $urandom_range(5, 12);
          default: deb = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 3))
          0: stall = $urandom_range(0, 3);
          1: stall = $urandom_range(4, 40);
          2: stall = $urandom_range(41, 300);
          default: stall = 65535;
        endcase
        apply_settings(deb, stall, $urandom_range(0, 255), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
      end
      if (phase == 3 || phase == 7) long_hold = 1'b1;
      back_to_back = ($urandom_range(0, 2) == 0);
      for (n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) c = CMD_TICK;
        else if (roll < 62) c = CMD_RAISE;
        else if (roll < 74) c = CMD_LOWER;
        else if (roll < 79) c = CMD_STOP;
        else if (roll < 84) c = CMD_CLEAR_FAULT;
        else if (roll < 93) c = CMD_SET_MAGNET;
        else if (roll < 97) c = CMD_SET_ALL;
        else c = CMD_UNUSED;
        // Switch levels hold for runs of ticks, with an occasional one-tick glitch.
        if (c == CMD_TICK) begin
          if ($urandom_range(0, 11) == 0) top_lvl = ~top_lvl;
          if ($urandom_range(0, 11) == 0) bot_lvl = ~bot_lvl;
          t = ($urandom_range(0, 19) == 0) ? ~top_lvl : top_lvl;
          b = ($urandom_range(0, 19) == 0) ? ~bot_lvl : bot_lvl;
        end else begin
          t = 1'($urandom_range(0, 1));
          b = 1'($urandom_range(0, 1));
        end
        send_item(c, t, b, IndexWidth'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        if (!back_to_back && $urandom_range(0, 2) == 0) pause_input(pick_gap());
      end
    end

    // A long motion under the highest stall limit never faults.
    apply_settings(0, 65535, $urandom_range(1, 255), 1'b1, 1'($urandom_range(0, 1)));
    send_item(CMD_CLEAR_FAULT, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_TICK, 1'b0, 1'b0, 3'd0, 1'b0);
    send_item(CMD_RAISE, 1'b0, 1'b0, 3'd0, 1'b0);
    for (n = 0; n < LongMoveTicks; n++) begin
      send_item(CMD_TICK, 1'b0, 1'b0, IndexWidth'($urandom_range(0, 7)),
                1'($urandom_range(0, 1)));
    end
    send_item(CMD_TICK, 1'b1, 1'b0, 3'd0, 1'b0);

    // Drain the remaining results, then let the block settle.
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
